>>> design/assert_macros.svh
// assertion macros for the tokenizer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset
`define WSCT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check a property on every clock edge, reset included
`define WSCT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> design/wsct_pkg.sv
// types, constants and helpers of the whitespace/comment/quote tokenizer
package wsct_pkg;

   // longest token limit and count width
   localparam int MaxLen     = 256;
   localparam int CountWidth = $clog2(MaxLen);
   localparam int LenWidth   = 8;

   // special byte values
   localparam logic [7:0] ByteTab   = 8'h09;
   localparam logic [7:0] ByteLf    = 8'h0a;
   localparam logic [7:0] ByteCr    = 8'h0d;
   localparam logic [7:0] ByteSpace = 8'h20;
   localparam logic [7:0] ByteHash  = 8'h23;
   localparam logic [7:0] ByteQuote = 8'h22;

   // scan mode, one-hot
   typedef enum logic [4:0] {
      MODE_SKIP    = 5'b00001,
      MODE_COMMENT = 5'b00010,
      MODE_PLAIN   = 5'b00100,
      MODE_QUOTED  = 5'b01000,
      MODE_HALTED  = 5'b10000
   } mode_type;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_CHAR    = 2'd0,
      KIND_DONE    = 2'd1,
      KIND_EOF     = 2'd2,
      KIND_TOOLONG = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_input;
   } req_word_type;

   typedef struct packed {
      kind_type              result_kind;
      logic [6:0]            token_char;
      logic [LenWidth-1:0]   token_length;
   } rsp_word_type;

   // scanner state carried between the step logic and its registers
   typedef struct packed {
      mode_type              mode;
      logic [CountWidth-1:0] count;
   } scan_state_type;

   // whitespace test: tab, newline, carriage return, space
   function automatic logic is_blank(input logic [7:0] b);
      return b inside {ByteTab, ByteLf, ByteCr, ByteSpace};
   endfunction

endpackage

>>> design/wsct_step.sv
// next-state and result logic for one byte of the tokenizer
module wsct_step (
   input  wsct_pkg::scan_state_type state,
   input  wsct_pkg::req_word_type   word,
   output wsct_pkg::scan_state_type next_state,
   output logic                     emit,
   output wsct_pkg::rsp_word_type   result
);

   localparam logic [wsct_pkg::CountWidth-1:0] CountLimit =
      wsct_pkg::CountWidth'(wsct_pkg::MaxLen - 1);

   logic at_limit;
   logic blank;

   assign at_limit = (state.count >= CountLimit);
   assign blank    = wsct_pkg::is_blank(word.in_byte);

   // mode update and result selection
   always_comb begin
      next_state = state;
      emit       = 1'b0;
      result     = '0;
      if (state.mode == wsct_pkg::MODE_HALTED) begin
         next_state = state;
      end else if (word.end_of_input) begin
         next_state.mode    = wsct_pkg::MODE_SKIP;
         next_state.count   = '0;
         emit               = 1'b1;
         result.result_kind = wsct_pkg::KIND_EOF;
      end else begin
         case (state.mode)
            wsct_pkg::MODE_COMMENT: begin
               if (word.in_byte == wsct_pkg::ByteLf) begin
                  next_state.mode = wsct_pkg::MODE_SKIP;
               end
            end
            wsct_pkg::MODE_PLAIN, wsct_pkg::MODE_QUOTED: begin
               emit = 1'b1;
               if ((state.mode == wsct_pkg::MODE_PLAIN && blank) ||
                   (state.mode == wsct_pkg::MODE_QUOTED &&
                    word.in_byte == wsct_pkg::ByteQuote)) begin
                  // token end
                  if (at_limit) begin
                     next_state.mode    = wsct_pkg::MODE_HALTED;
                     result.result_kind = wsct_pkg::KIND_TOOLONG;
                  end else begin
                     next_state.mode     = wsct_pkg::MODE_SKIP;
                     next_state.count    = '0;
                     result.result_kind  = wsct_pkg::KIND_DONE;
                     result.token_length = wsct_pkg::LenWidth'(state.count);
                  end
               end else begin
                  // token character
                  if (at_limit) begin
                     next_state.mode    = wsct_pkg::MODE_HALTED;
                     result.result_kind = wsct_pkg::KIND_TOOLONG;
                  end else begin
                     next_state.count   = state.count + wsct_pkg::CountWidth'(1);
                     result.result_kind = wsct_pkg::KIND_CHAR;
                     result.token_char  = word.in_byte[6:0];
                  end
               end
            end
            default: begin
               // between tokens
               next_state.mode = wsct_pkg::MODE_SKIP;
               if (word.in_byte == wsct_pkg::ByteHash) begin
                  next_state.mode = wsct_pkg::MODE_COMMENT;
               end else if (word.in_byte == wsct_pkg::ByteQuote) begin
                  next_state.mode  = wsct_pkg::MODE_QUOTED;
                  next_state.count = '0;
               end else if (!blank) begin
                  // first character of a plain token, limit is at least one
                  next_state.mode    = wsct_pkg::MODE_PLAIN;
                  next_state.count   = wsct_pkg::CountWidth'(1);
                  emit               = 1'b1;
                  result.result_kind = wsct_pkg::KIND_CHAR;
                  result.token_char  = word.in_byte[6:0];
               end
            end
         endcase
      end
   end

endmodule

>>> design/whitespace_comment_quote_tokenizer_core.sv
// Whitespace tokenizer with hash comments and quoted tokens, one byte per word.
// A taken byte is held in the req stage; its result word is then registered on rsp_.
// Throughput: one byte per cycle while rsp_stall does not hold the result register.
// A stalled result register holds the pipeline; one input word waits in req stage.
// Reset (synchronous, active high) empties both stages, mode to skipping, count 0.
`include "assert_macros.svh"

module whitespace_comment_quote_tokenizer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  wsct_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output wsct_pkg::rsp_word_type rsp_word
);

   logic                     in_valid_ff, in_valid_in;
   wsct_pkg::req_word_type   in_word_ff;
   wsct_pkg::scan_state_type state_ff, state_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   wsct_pkg::rsp_word_type   rsp_word_ff;

   wsct_pkg::scan_state_type step_state;
   logic                     step_emit;
   wsct_pkg::rsp_word_type   step_result;
   logic                     advance;
   logic                     req_take;

   wsct_step u_step (
      .state      (state_ff),
      .word       (in_word_ff),
      .next_state (step_state),
      .emit       (step_emit),
      .result     (step_result)
   );

   // the held byte moves on when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_take || (in_valid_ff && !advance);
      state_in     = advance ? step_state : state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = step_emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff.mode  <= wsct_pkg::MODE_SKIP;
         state_ff.count <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance && step_emit) begin
         rsp_word_ff <= step_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // checks
   `WSCT_ASSERT(a_halt_sticks, state_ff.mode == wsct_pkg::MODE_HALTED |=> state_ff.mode == wsct_pkg::MODE_HALTED, "halted mode left without reset")
   `WSCT_ASSERT(a_idle_count_zero, (state_ff.mode == wsct_pkg::MODE_SKIP || state_ff.mode == wsct_pkg::MODE_COMMENT) |-> state_ff.count == '0, "count nonzero between tokens")
   `WSCT_ASSERT(a_halt_silent, advance && state_ff.mode == wsct_pkg::MODE_HALTED |=> !rsp_valid_ff, "result produced while halted")
   `WSCT_ASSERT(a_toolong_halts, rsp_valid_ff && rsp_word_ff.result_kind == wsct_pkg::KIND_TOOLONG |-> state_ff.mode == wsct_pkg::MODE_HALTED, "overlong token did not halt")

endmodule

>>> test/tb.sv
// self-checking testbench for the whitespace/comment/quote tokenizer core
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wsct_pkg::*;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word  = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   whitespace_comment_quote_tokenizer_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // byte words waiting to be sent, result words still owed by the block
   req_word_type pending_words[$];
   rsp_word_type expected_words[$];

   // tokenizer state as the testbench sees it
   mode_type scan_mode = MODE_SKIP;
   int       tok_count = 0;

   int items_taken    = 0;
   int total_items    = 0;
   int mismatch_count = 0;
   int pressure_point = 0;
   int hold_left      = 0;
   bit hold_done      = 1'b0;
   bit req_fire       = 1'b0;

   always #5 clock = ~clock;

   function automatic bit is_space_byte(input logic [7:0] b);
      return b == ByteTab || b == ByteLf || b == ByteCr || b == ByteSpace;
   endfunction

   // advance the tokenizer by one byte word and queue the result it owes
   function automatic void tokenize_byte(input req_word_type w);
      rsp_word_type r;
      logic [7:0]   b;
      bit           adding;
      bit           closing;
      bit           emit;
      r       = '0;
      b       = w.in_byte;
      adding  = 1'b0;
      closing = 1'b0;
      emit    = 1'b0;
      if (scan_mode != MODE_HALTED) begin
         if (w.end_of_input) begin
            scan_mode     = MODE_SKIP;
            tok_count     = 0;
            r.result_kind = KIND_EOF;
            emit          = 1'b1;
         end else begin
            case (scan_mode)
               MODE_COMMENT: begin
                  if (b == ByteLf) scan_mode = MODE_SKIP;
               end
               MODE_PLAIN: begin
                  if (is_space_byte(b)) closing = 1'b1;
                  else adding = 1'b1;
               end
               MODE_QUOTED: begin
                  if (b == ByteQuote) closing = 1'b1;
                  else adding = 1'b1;
               end
               default: begin
                  if (b == ByteHash) begin
                     scan_mode = MODE_COMMENT;
                  end else if (b == ByteQuote) begin
                     scan_mode = MODE_QUOTED;
                     tok_count = 0;
                  end else if (!is_space_byte(b)) begin
                     scan_mode = MODE_PLAIN;
                     tok_count = 0;
                     adding    = 1'b1;
                  end
               end
            endcase
         end
         // character or token end, unless the token hit the length limit
         if (adding || closing) begin
            emit = 1'b1;
            if (tok_count >= MaxLen - 1) begin
               scan_mode     = MODE_HALTED;
               r.result_kind = KIND_TOOLONG;
            end else if (adding) begin
               tok_count++;
               r.result_kind = KIND_CHAR;
               r.token_char  = b[6:0];
            end else begin
               r.result_kind  = KIND_DONE;
               r.token_length = tok_count[7:0];
               scan_mode      = MODE_SKIP;
               tok_count      = 0;
            end
         end
      end
      if (emit) expected_words.push_back(r);
   endfunction

   // ---------------- stimulus helpers

   function automatic req_word_type word_of(input logic [7:0] b, input bit eof);
      req_word_type w;
      w.in_byte      = b;
      w.end_of_input = eof;
      return w;
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      pending_words.push_back(word_of(b, 1'b0));
   endfunction

   function automatic void add_eof();
      pending_words.push_back(word_of(8'($urandom_range(0, 255)), 1'b1));
   endfunction

   function automatic logic [7:0] random_blank();
      case ($urandom_range(0, 3))
         0: return ByteTab;
         1: return ByteLf;
         2: return ByteCr;
         default: return ByteSpace;
      endcase
   endfunction

   // random byte avoiding the chosen delimiter classes
   function automatic logic [7:0] pick_byte(input bit no_blank, input bit no_quote,
                                            input bit no_lf, input bit no_hash);
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while ((no_blank && is_space_byte(b)) || (no_quote && b == ByteQuote) ||
                 (no_lf && b == ByteLf) || (no_hash && b == ByteHash));
      return b;
   endfunction

   function automatic void add_plain(input int len, input bit end_by_eof);
      add_byte(pick_byte(1, 1, 0, 1));
      for (int i = 1; i < len; i++) add_byte(pick_byte(1, 0, 0, 0));
      if (end_by_eof) add_eof();
      else add_byte(random_blank());
   endfunction

   function automatic void add_quoted(input int len, input bit end_by_eof);
      add_byte(ByteQuote);
      for (int i = 0; i < len; i++) add_byte(pick_byte(0, 1, 0, 0));
      if (end_by_eof) add_eof();
      else add_byte(ByteQuote);
   endfunction

   function automatic int token_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(13, 60);
      return $urandom_range(1, 12);
   endfunction

   // well-formed segments with random content, plus some noise
   function automatic void add_random_segments(input int count);
      int stop_at;
      int pick;
      stop_at = pending_words.size() + count;
      while (pending_words.size() < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 15) begin
            repeat ($urandom_range(1, 3)) add_byte(random_blank());
         end else if (pick < 45) begin
            add_plain(token_len(), $urandom_range(0, 9) == 0);
         end else if (pick < 70) begin
            add_quoted(token_len() - 1, $urandom_range(0, 9) == 0);
         end else if (pick < 80) begin
            add_byte(ByteHash);
            repeat ($urandom_range(0, 8)) add_byte(pick_byte(0, 0, 1, 0));
            if ($urandom_range(0, 9) == 0) add_eof();
            else add_byte(ByteLf);
         end else if (pick < 88) begin
            add_eof();
         end else begin
            repeat ($urandom_range(1, 4))
               pending_words.push_back(word_of(8'($urandom_range(0, 255)),
                                               $urandom_range(0, 9) == 0));
         end
      end
   endfunction

   // idle percentages: sender 33/receiver 66, then swapped, then none
   function automatic int idle_phase();
      if (items_taken < total_items / 3) return 0;
      if (items_taken < 2 * total_items / 3) return 1;
      return 2;
   endfunction

   // ---------------- driver

   always @(negedge clock) begin
      int pct;
      pct = (idle_phase() == 0) ? 33 : (idle_phase() == 1) ? 66 : 0;
      if (!reset && (!req_valid || req_fire)) begin
         if (pending_words.size() != 0 && $urandom_range(0, 99) >= pct) begin
            req_valid <= 1'b1;
            req_word  <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall, with one long hold-off inside the final long token
   always @(negedge clock) begin
      int pct;
      pct = (idle_phase() == 0) ? 66 : (idle_phase() == 1) ? 33 : 0;
      if (!reset) begin
         if (!hold_done && pressure_point != 0 && items_taken >= pressure_point) begin
            hold_left = 60;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < pct);
         end
      end
   end

   // ---------------- monitor

   always @(posedge clock) begin
      rsp_word_type want;
      req_fire = !reset && req_valid && !req_stall;
      if (req_fire) begin
         tokenize_byte(req_word);
         items_taken++;
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $error("unexpected result word kind %0d char %0d length %0d",
                   rsp_word.result_kind, rsp_word.token_char, rsp_word.token_length);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            if (rsp_word.result_kind !== want.result_kind) begin
               $error("result_kind expected %0d got %0d", want.result_kind,
                      rsp_word.result_kind);
               mismatch_count++;
            end
            if (rsp_word.token_char !== want.token_char) begin
               $error("token_char expected %0d got %0d", want.token_char,
                      rsp_word.token_char);
               mismatch_count++;
            end
            if (rsp_word.token_length !== want.token_length) begin
               $error("token_length expected %0d got %0d", want.token_length,
                      rsp_word.token_length);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------- stimulus and end of run

   initial begin
      bit quoted;
      // plain token with high-bit and zero bytes, ended by newline
      add_byte(8'hff); add_byte(8'h00); add_byte(8'h80); add_byte(ByteLf);
      // blanks between tokens
      add_byte(ByteTab); add_byte(ByteCr); add_byte(ByteSpace);
      // comment holding a quote
      add_byte(ByteHash); add_byte("x"); add_byte(ByteQuote); add_byte(ByteLf);
      // quoted token with literal space and hash
      add_byte(ByteQuote); add_byte(ByteSpace); add_byte(ByteHash); add_byte(ByteQuote);
      // empty quoted token
      add_byte(ByteQuote); add_byte(ByteQuote);
      // quote inside a plain token, ended by tab
      add_byte("b"); add_byte(ByteQuote); add_byte(ByteTab);
      // end of input while skipping, in a plain token, in a quoted token, in a comment
      add_eof();
      add_byte("z"); add_eof();
      add_byte(ByteQuote); add_byte("k"); add_eof();
      add_byte(ByteHash); add_eof();

      add_random_segments(50);
      // longest token that still completes
      if ($urandom_range(0, 1)) add_quoted(MaxLen - 2, 1'b0);
      else add_plain(MaxLen - 2, 1'b0);
      add_random_segments(50);

      // overlong token halts the block for the rest of the run
      quoted = 1'($urandom_range(0, 1));
      pressure_point = pending_words.size() + 100;
      if (quoted) begin
         add_byte(ByteQuote);
         repeat (MaxLen - 1) add_byte(pick_byte(0, 1, 0, 0));
         add_byte($urandom_range(0, 1) ? ByteQuote : pick_byte(0, 1, 0, 0));
      end else begin
         add_byte(pick_byte(1, 1, 0, 1));
         repeat (MaxLen - 2) add_byte(pick_byte(1, 0, 0, 0));
         add_byte($urandom_range(0, 1) ? random_blank() : pick_byte(1, 0, 0, 0));
      end
      add_eof(); add_byte(ByteQuote); add_byte("a"); add_eof(); add_byte(ByteSpace);
      total_items = pending_words.size();

      repeat (12) @(negedge clock);
      reset <= 1'b0;

      while (items_taken < total_items || expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
